// ===== hw/rtl/jaos_pkg.sv =====
// Shared types and constants for the JSON array object splitter.
package jaos_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_KEY     = 3'd1,
    PH_BETWEEN = 3'd2,
    PH_OBJECT  = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_LAST = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Search patterns, entry 0 is the first byte matched
  localparam logic [2:0] HDR_LEN = 3'd4;
  localparam logic [2:0] KEY_LEN = 3'd6;
  localparam logic [3:0][7:0] HDR_PAT = {8'h0A, 8'h0D, 8'h0A, 8'h0D};
  localparam logic [5:0][7:0] KEY_PAT = {8'h5B, 8'h3A, 8'h22, 8'h63, 8'h61, 8'h22};

  // Special characters
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  localparam logic [15:0] CNT_MAX       = 16'hFFFF;
  localparam logic [15:0] MAX_BYTES_RST = 16'd2047;

  // Request payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_response;
  } item_t;

  // Result payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] item_kind;
    logic       first_of_object;
    logic       truncated;
  } result_t;

endpackage

// ===== hw/rtl/http_json_array_object_splitter.sv =====
// Top level: request register, framing parser and result register.
// A request passes from the request register through the combinational parser into the result register.
// Throughput: one byte per cycle; the input register and result register
// advance together and both hold while a shown result is stalled.
// Reset (rst, synchronous): parser back to header search, no result held,
// max_object_bytes back to 2047.
module http_json_array_object_splitter (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  jaos_pkg::item_t    item,
  output logic               result_valid,
  input  logic               result_stall,
  output jaos_pkg::result_t  result
);

  logic              advance;
  logic              req_valid;
  jaos_pkg::item_t   req;
  logic [15:0]       max_object_bytes;
  logic              res_valid;
  jaos_pkg::result_t res;

  // Whole pipe moves unless a shown result is stalled
  assign advance    = !result_valid || !result_stall;
  assign item_stall = !advance;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_object_bytes <= jaos_pkg::MAX_BYTES_RST;
    end else if (cfg_wr_en) begin
      max_object_bytes <= cfg_wr_data;
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (advance) begin
      req_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      req <= item;
    end
  end

  jaos_parse u_parse (
    .clk              (clk),
    .rst              (rst),
    .en               (advance && req_valid),
    .item             (req),
    .max_object_bytes (max_object_bytes),
    .res_valid        (res_valid),
    .res              (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= req_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

endmodule

// ===== hw/rtl/jaos_parse.sv =====
// Parser state and per-byte framing logic.
module jaos_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  jaos_pkg::item_t     item,
  input  logic [15:0]         max_object_bytes,
  output logic                res_valid,
  output jaos_pkg::result_t   res
);

  jaos_pkg::phase_t phase, phase_next, cur_phase;
  logic [2:0]  header_match_len, header_match_len_next, cur_hm, hm_adv;
  logic [2:0]  key_match_len, key_match_len_next, cur_km, km_adv;
  logic [15:0] brace_depth, brace_depth_next, cur_depth, depth_dec;
  logic        inside_string, inside_string_next, cur_str;
  logic        escape_pending, escape_pending_next, cur_esc;
  logic [15:0] bytes_emitted, bytes_emitted_next, cur_cnt;
  logic        dropped_flag, dropped_flag_next, cur_drop;
  logic        closes;
  logic [7:0]  c;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= jaos_pkg::PH_HEADER;
      header_match_len <= '0;
      key_match_len    <= '0;
      brace_depth      <= '0;
      inside_string    <= 1'b0;
      escape_pending   <= 1'b0;
      bytes_emitted    <= '0;
      dropped_flag     <= 1'b0;
    end else if (en) begin
      phase            <= phase_next;
      header_match_len <= header_match_len_next;
      key_match_len    <= key_match_len_next;
      brace_depth      <= brace_depth_next;
      inside_string    <= inside_string_next;
      escape_pending   <= escape_pending_next;
      bytes_emitted    <= bytes_emitted_next;
      dropped_flag     <= dropped_flag_next;
    end
  end

  // Next state and result for one byte
  always_comb begin
    c = item.data_byte;
    // new response clears everything before the byte is handled
    cur_phase = item.new_response ? jaos_pkg::PH_HEADER : phase;
    cur_hm    = item.new_response ? 3'd0  : header_match_len;
    cur_km    = item.new_response ? 3'd0  : key_match_len;
    cur_depth = item.new_response ? 16'd0 : brace_depth;
    cur_str   = item.new_response ? 1'b0  : inside_string;
    cur_esc   = item.new_response ? 1'b0  : escape_pending;
    cur_cnt   = item.new_response ? 16'd0 : bytes_emitted;
    cur_drop  = item.new_response ? 1'b0  : dropped_flag;

    phase_next            = cur_phase;
    header_match_len_next = cur_hm;
    key_match_len_next    = cur_km;
    brace_depth_next      = cur_depth;
    inside_string_next    = cur_str;
    escape_pending_next   = cur_esc;
    bytes_emitted_next    = cur_cnt;
    dropped_flag_next     = cur_drop;
    res_valid             = 1'b0;
    res                   = '0;
    closes                = 1'b0;

    // match extension with fall back to a one-byte partial match
    if (cur_hm < jaos_pkg::HDR_LEN && c == jaos_pkg::HDR_PAT[cur_hm[1:0]]) begin
      hm_adv = cur_hm + 3'd1;
    end else begin
      hm_adv = {2'b00, c == jaos_pkg::HDR_PAT[0]};
    end
    if (cur_km < jaos_pkg::KEY_LEN && c == jaos_pkg::KEY_PAT[cur_km]) begin
      km_adv = cur_km + 3'd1;
    end else begin
      km_adv = {2'b00, c == jaos_pkg::KEY_PAT[0]};
    end
    depth_dec = (cur_depth != 16'd0) ? cur_depth - 16'd1 : cur_depth;

    case (cur_phase)
      jaos_pkg::PH_HEADER: begin
        if (hm_adv == jaos_pkg::HDR_LEN) begin
          header_match_len_next = 3'd0;
          phase_next            = jaos_pkg::PH_KEY;
        end else begin
          header_match_len_next = hm_adv;
        end
      end
      jaos_pkg::PH_KEY: begin
        if (km_adv == jaos_pkg::KEY_LEN) begin
          key_match_len_next = 3'd0;
          phase_next         = jaos_pkg::PH_BETWEEN;
        end else begin
          key_match_len_next = km_adv;
        end
      end
      jaos_pkg::PH_BETWEEN: begin
        if (c == jaos_pkg::CH_LBRACE) begin
          phase_next          = jaos_pkg::PH_OBJECT;
          brace_depth_next    = 16'd1;
          inside_string_next  = 1'b0;
          escape_pending_next = 1'b0;
          bytes_emitted_next  = 16'd1;
          dropped_flag_next   = 1'b0;
          res_valid           = 1'b1;
          res.out_byte        = c;
          res.item_kind       = jaos_pkg::KIND_BYTE;
          res.first_of_object = 1'b1;
        end else if (c == jaos_pkg::CH_RBRACK) begin
          phase_next    = jaos_pkg::PH_DONE;
          res_valid     = 1'b1;
          res.item_kind = jaos_pkg::KIND_END;
        end
      end
      jaos_pkg::PH_OBJECT: begin
        // escape, string and depth tracking
        if (cur_esc) begin
          escape_pending_next = 1'b0;
        end else if (c == jaos_pkg::CH_BSLASH) begin
          escape_pending_next = 1'b1;
        end else if (c == jaos_pkg::CH_QUOTE) begin
          inside_string_next = !cur_str;
        end else if (!cur_str) begin
          if (c == jaos_pkg::CH_LBRACE) begin
            if (cur_depth != jaos_pkg::CNT_MAX) begin
              brace_depth_next = cur_depth + 16'd1;
            end
          end else if (c == jaos_pkg::CH_RBRACE) begin
            brace_depth_next = depth_dec;
            closes           = (depth_dec == 16'd0);
          end
        end
        // emit, limit or close
        if (closes) begin
          phase_next          = jaos_pkg::PH_BETWEEN;
          inside_string_next  = 1'b0;
          escape_pending_next = 1'b0;
          bytes_emitted_next  = 16'd0;
          dropped_flag_next   = 1'b0;
          res_valid           = 1'b1;
          res.out_byte        = c;
          res.item_kind       = jaos_pkg::KIND_LAST;
          res.truncated       = cur_drop;
        end else if (cur_cnt < max_object_bytes) begin
          if (cur_cnt != jaos_pkg::CNT_MAX) begin
            bytes_emitted_next = cur_cnt + 16'd1;
          end
          res_valid     = 1'b1;
          res.out_byte  = c;
          res.item_kind = jaos_pkg::KIND_BYTE;
        end else begin
          dropped_flag_next = 1'b1;
        end
      end
      default: begin
        // array done: ignore until a new response
      end
    endcase
  end

endmodule

// ===== hw/rtl/jaos_checker.sv =====
// Port-level checks for the splitter, bound to the top level.
module jaos_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_stall,
  input logic               result_valid,
  input logic               result_stall,
  input jaos_pkg::result_t  result
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Requests only back up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("request stalled without a stalled result");

  // Opening brace is a plain object byte
  a_first: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.first_of_object |->
      result.out_byte == jaos_pkg::CH_LBRACE && result.item_kind == jaos_pkg::KIND_BYTE)
    else $error("bad first-of-object result");

  // Truncation only flagged on a closing brace
  a_trunc: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.truncated |->
      result.item_kind == jaos_pkg::KIND_LAST && result.out_byte == jaos_pkg::CH_RBRACE)
    else $error("truncated outside final byte");

  // Array end carries a zero byte and no flags
  a_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.item_kind == jaos_pkg::KIND_END |->
      result.out_byte == 8'h00 && !result.first_of_object && !result.truncated)
    else $error("bad array-end result");

endmodule

bind http_json_array_object_splitter jaos_checker u_jaos_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
